// ===== design/dht_pkg.sv =====
// ----------------------------------------------------------------------------
// dht_pkg: shared types and constants of the deadline hold table
// Request and result formats, codes and table sizes.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int Capacity = 16;
  localparam int KeyBytes = 8;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int RowW = 64 + 2 + 64 + 2;

  localparam logic [1:0] OP_SET     = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_DUE     = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_KEEP    = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_KIND      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic CFG_DEFAULT_KEEP = 1'b0;
  localparam logic CFG_ROW_LIMIT    = 1'b1;

  localparam logic [63:0] KeyMask =
    (KeyBytes >= 8) ? '1 : ((64'd1 << (8 * KeyBytes)) - 64'd1);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [1:0]  mode;
    logic [63:0] deadline;
    logic [1:0]  then_mode;
    logic [63:0] now_time;
    logic [4:0]  list_limit;
  } dht_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  effective_mode;
    logic        keeps;
    logic        due_valid;
    logic [63:0] due_key;
    logic [4:0]  dropped_count;
    logic [4:0]  hold_count;
    logic        last;
  } dht_res_t;

  typedef struct packed {
    logic [63:0] key;
    logic [1:0]  mode;
    logic [63:0] deadline;
    logic [1:0]  then_mode;
  } dht_row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_MOVE,
    S_OUT
  } dht_state_t;

endpackage

// ===== design/dht_ram.sv =====
// ----------------------------------------------------------------------------
// dht_ram: generic single-port-write, single-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module dht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/deadline_hold_table_core.sv =====
// ----------------------------------------------------------------------------
// deadline_hold_table_core: per-key retention holds with deadlines
// Set, query and due listing over a row table held in one RAM.
// ----------------------------------------------------------------------------
// Usage: a request enters on req/req_valid and is taken at a clock edge where
// req_valid is high and req_stall is low. Results leave on res/res_valid and
// are taken when res_stall is low. Set and query give one result; a due
// listing gives one result per listed key, or one empty result.
// Set, query and due listing scan the rows in use one per cycle through the
// row RAM (one read port, registered read data) while no due result is
// stalled; a set that fails its checks and an invalid opcode skip the scan.
// A set or query that hits stops the scan at the hit row. A set then passes
// through the write state, and a remove of a row other than the last one
// also through the move state, which copies the last row into the freed one.
// Extra due results leave while the scan runs, and the scan waits only when
// one of them finds the output register occupied. The next request is taken
// once the final result is loaded. Only one request is in work at a time;
// req_stall is high while busy. A stalled result holds in the output register.
// Reset (rst, synchronous) empties the table and restores default_keep = 0
// and row_limit = 16; row contents are not cleared, as read data of rows at
// or above the used count is never used. Registers are written through
// cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module deadline_hold_table_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  dht_pkg::dht_req_t req,
  output logic              res_valid,
  input  logic              res_stall,
  output dht_pkg::dht_res_t res,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data
);
  import dht_pkg::*;

  // Configuration registers.
  logic       default_keep;
  logic [4:0] row_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_keep <= 1'b0;
      row_limit    <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEFAULT_KEEP: default_keep <= cfg_data[0];
        CFG_ROW_LIMIT:    row_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state and the request being worked on.
  dht_state_t state, state_next;
  dht_req_t   cur;
  logic [CntW-1:0] rows_used;
  logic [CntW-1:0] scan;      // row whose read is outstanding
  logic            rd_pend;   // RAM data for row scan - 1 is valid this cycle
  logic            found;
  logic [IdxW-1:0] hit_row;
  dht_row_t        hit_data;
  logic [CntW-1:0] listed;
  logic [CntW-1:0] dropped;
  logic            move_rd;   // last row read issued for a remove
  logic            refused;   // a new key found the table full in S_WRITE

  // Row RAM.
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  dht_row_t        ram_wdata, ram_rdata;

  dht_ram #(.Width(RowW), .Depth(Capacity)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective key and limits.
  logic [63:0]     cur_key;
  logic [CntW-1:0] lim_rows, lim_list;
  assign cur_key  = cur.key & KeyMask;
  assign lim_rows = (row_limit > 5'(Capacity)) ? CntW'(Capacity) : CntW'(row_limit);
  assign lim_list = (cur.list_limit > 5'(Capacity)) ? CntW'(Capacity)
                                                    : CntW'(cur.list_limit);

  // Row comparison on the returned read data.
  logic row_hit, row_due;
  assign row_hit = rd_pend && (ram_rdata.key == cur_key);
  assign row_due = rd_pend && (ram_rdata.deadline != 64'd0) &&
                   (cur.now_time >= ram_rdata.deadline);

  logic scan_done;
  assign scan_done = !rd_pend && (scan >= rows_used);

  // Output register.
  logic     out_free;
  dht_res_t res_next;
  logic     res_load;
  assign out_free = !res_valid || !res_stall;

  // The scan stalls while a due result waits for the output register.
  logic scan_hold;
  assign scan_hold = (state == S_SCAN) && cur.opcode == OP_DUE && row_due &&
                     found && listed < lim_list && !out_free;

  logic set_err;
  logic [1:0] set_err_st;
  always_comb begin
    set_err    = 1'b1;
    set_err_st = ST_OK;
    priority if (cur.mode == MODE_UNKNOWN || cur.then_mode == MODE_UNKNOWN) begin
      set_err_st = ST_KIND;
    end else if (cur.mode == MODE_DEFAULT && cur.deadline != 64'd0) begin
      set_err_st = ST_MALFORMED;
    end else begin
      set_err = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_SCAN;
      S_SCAN: begin
        if (cur.opcode == OP_SET && set_err) begin
          state_next = S_OUT;
        end else if (cur.opcode == OP_DUE) begin
          if (scan_done) state_next = S_OUT;
        end else if (cur.opcode == OP_SET || cur.opcode == OP_QUERY) begin
          if (scan_done || row_hit || found) begin
            state_next = (cur.opcode == OP_SET) ? S_WRITE : S_OUT;
          end
        end else begin
          state_next = S_OUT;
        end
      end
      S_WRITE: begin
        if (cur.mode == MODE_DEFAULT && found &&
            CntW'(hit_row) != rows_used - CntW'(1)) begin
          state_next = S_MOVE;
        end else begin
          state_next = S_OUT;
        end
      end
      S_MOVE: if (move_rd) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_row;
    ram_wdata = ram_rdata;
    // While the scan holds, the row under compare is read again.
    ram_raddr = scan_hold ? IdxW'(scan - CntW'(1)) : scan[IdxW-1:0];
    res_load  = 1'b0;
    res_next  = '0;
    res_next.hold_count = 5'(rows_used);
    req_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE, S_SCAN: ;
      S_WRITE: begin
        if (cur.mode != MODE_DEFAULT) begin
          ram_we    = !(!found && rows_used >= lim_rows);
          ram_waddr = found ? hit_row : rows_used[IdxW-1:0];
          ram_wdata.key       = cur_key;
          ram_wdata.mode      = cur.mode;
          ram_wdata.deadline  = cur.deadline;
          ram_wdata.then_mode = (cur.deadline == 64'd0) ? MODE_DEFAULT : cur.then_mode;
        end
        ram_raddr = IdxW'(rows_used - CntW'(1));
      end
      S_MOVE: begin
        // The count is already lowered, so it names the old last row.
        ram_raddr = IdxW'(rows_used);
        ram_we    = move_rd;
        ram_waddr = hit_row;
        ram_wdata = ram_rdata;
      end
      S_OUT: begin
        res_load = out_free;
        res_next.last = 1'b1;
        unique case (cur.opcode)
          OP_SET: begin
            if (set_err) res_next.status = set_err_st;
            else if (refused) res_next.status = ST_RANGE;
          end
          OP_QUERY: begin
            if (found) begin
              res_next.effective_mode =
                (hit_data.deadline != 64'd0 && cur.now_time >= hit_data.deadline)
                ? hit_data.then_mode : hit_data.mode;
            end
            res_next.keeps = (res_next.effective_mode == MODE_KEEP) ? 1'b1 :
                             (res_next.effective_mode == MODE_DROP) ? 1'b0 : default_keep;
          end
          OP_DUE: begin
            res_next.dropped_count = 5'(dropped);
            if (found) begin
              res_next.due_valid = 1'b1;
              res_next.due_key   = hit_data.key;
            end
          end
          default: res_next.status = ST_MALFORMED;
        endcase
      end
      default: ;
    endcase
    // A due row that will be listed while a listed one is still held sends
    // the held one out.
    if (state == S_SCAN && cur.opcode == OP_DUE && row_due && found &&
        listed < lim_list) begin
      res_next = '0;
      res_next.hold_count = 5'(rows_used);
      res_next.due_valid  = 1'b1;
      res_next.due_key    = hit_data.key;
      res_load = out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rows_used <= '0;
      scan      <= '0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      listed    <= '0;
      dropped   <= '0;
      move_rd   <= 1'b0;
      refused   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= scan_hold ? state : state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          scan    <= '0;
          rd_pend <= 1'b0;
          found   <= 1'b0;
          listed  <= '0;
          dropped <= '0;
          move_rd <= 1'b0;
          refused <= 1'b0;
        end
        S_SCAN: begin
          if (!scan_hold) begin
            rd_pend <= (scan < rows_used);
            if (scan < rows_used) scan <= scan + CntW'(1);
            if (cur.opcode == OP_DUE) begin
              if (row_due) begin
                if (listed < lim_list) begin
                  found  <= 1'b1;
                  listed <= listed + CntW'(1);
                end else begin
                  dropped <= dropped + CntW'(1);
                end
              end
            end else if (row_hit && !found) begin
              found   <= 1'b1;
              hit_row <= IdxW'(scan - CntW'(1));
            end
          end
        end
        S_WRITE: begin
          refused <= (cur.mode != MODE_DEFAULT) && !found && (rows_used >= lim_rows);
          if (cur.mode == MODE_DEFAULT) begin
            if (found) rows_used <= rows_used - CntW'(1);
          end else if (!found && rows_used < lim_rows) begin
            rows_used <= rows_used + CntW'(1);
          end
        end
        S_MOVE: move_rd <= 1'b1;
        default: ;
      endcase
    end
  end

  // Captured row data and request payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) cur <= req;
    if (state == S_SCAN && !scan_hold && (cur.opcode == OP_DUE ? row_due && listed < lim_list
                                                                : row_hit && !found)) begin
      hit_data <= ram_rdata;
    end
    if (res_load) res <= res_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rows_used <= CntW'(Capacity))
    else $error("row count above capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> req_stall)
    else $error("request accepted while busy");
  a_res_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> res_valid && res.last)
    else $error("final result missing");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rows_used != $past(rows_used) |-> $past(state) == S_WRITE)
    else $error("row count changed outside write");
`endif

endmodule
